// ----- hw/rtl/olist_pkg.sv -----
// Shared types and constants of the ordered list engine.
// Used by olist_cell, olist_first and ordered_list_engine; no dependencies.
package olist_pkg;

    // List geometry
    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 4;
    localparam int ST_W     = 2;

    // First-match search works in groups of eight cells
    localparam int GRP      = 8;
    localparam int OFF_W    = 3;
    localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;
    localparam int GSEL_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PADDED_W = NGRP * GRP;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH      = 4'd0,
        OP_POP       = 4'd1,
        OP_UNSHIFT   = 4'd2,
        OP_SHIFT     = 4'd3,
        OP_INSERT    = 4'd4,
        OP_GET       = 4'd5,
        OP_PUT       = 4'd6,
        OP_REMOVE_AT = 4'd7,
        OP_FIND      = 4'd8,
        OP_REMOVE_V  = 4'd9
    } op_t;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // What every cell does at the commit edge
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_WRITE  = 3'd1,
        CELL_OPEN   = 3'd2,
        CELL_CLOSE  = 3'd3,
        CELL_EXTEND = 3'd4
    } cell_mode_t;

    // Control broadcast along the row of cells
    typedef struct packed {
        cell_mode_t         mode;
        logic [IDX_W-1:0]   pos;
        logic [CNT_W-1:0]   cnt;
        logic [IDX_W-1:0]   rd_idx;
        logic [VALUE_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/ordered_list_engine.sv -----
// Ordered list engine: a bounded list of 32-bit values held in a row of
// cells, with push/pop/unshift/shift/insert/get/put/remove/find operations.
// Input channel: item_valid/item_stall with operation, position, item_value.
// An item is taken when item_valid is high and item_stall low.
// Output channel: result_valid/result_stall with out_value, out_position,
// hit, count and status; exactly one result item per input item.
// An item passes through four core steps (key compare in every cell,
// first-match encode, gated read of the addressed cell, commit), and its
// result is visible the cycle after commit. The next item is taken only
// once the engine is back in the idle step after that commit; item_stall
// is high while an item is in the core.
// The output register holds a finished result while result_stall is high;
// a new item is still accepted then, and the core waits at the commit step
// until the output register frees.
// Reset (rst_n low, asynchronous) empties the list and drops any pending
// result; entry contents are not cleared, only the count.
module ordered_list_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [olist_pkg::OP_W-1:0]    operation,
    input  logic [olist_pkg::IDX_W-1:0]   position,
    input  logic [olist_pkg::VALUE_W-1:0] item_value,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [olist_pkg::VALUE_W-1:0] out_value,
    output logic [olist_pkg::IDX_W-1:0]   out_position,
    output logic                          hit,
    output logic [olist_pkg::CNT_W-1:0]   count,
    output logic [olist_pkg::ST_W-1:0]    status
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_LOC  = 5'b00100,
        S_RD   = 5'b01000,
        S_EXEC = 5'b10000
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    olist_pkg::op_t                op_reg;
    logic [olist_pkg::IDX_W-1:0]   pos_reg;
    logic [olist_pkg::VALUE_W-1:0] val_reg;
    logic [olist_pkg::CNT_W-1:0]   cnt_reg;
    logic [olist_pkg::CNT_W-1:0]   cnt_next;
    logic                          found_reg;
    logic [olist_pkg::IDX_W-1:0]   fpos_reg;

    logic                          out_valid_reg;
    logic [olist_pkg::VALUE_W-1:0] out_value_reg;
    logic [olist_pkg::IDX_W-1:0]   out_pos_reg;
    logic                          out_hit_reg;
    logic [olist_pkg::CNT_W-1:0]   out_cnt_reg;
    olist_pkg::status_t            out_status_reg;

    logic                          accept;
    logic                          commit;
    logic [olist_pkg::CAPACITY-1:0] match_vec;
    logic [olist_pkg::VALUE_W-1:0] cell_val [olist_pkg::CAPACITY];
    logic [olist_pkg::VALUE_W-1:0] cell_rd  [olist_pkg::CAPACITY];
    logic                          enc_found;
    logic [olist_pkg::IDX_W-1:0]   enc_first;
    olist_pkg::cell_ctrl_t         ctrl;
    olist_pkg::cell_mode_t         mode;
    logic [olist_pkg::IDX_W-1:0]   cmd_pos;
    logic [olist_pkg::IDX_W-1:0]   rd_idx;
    logic [olist_pkg::CNT_W-1:0]   cnt_dec;
    logic [olist_pkg::VALUE_W-1:0] rd_word;

    // Result fields of the operation in flight
    logic [olist_pkg::VALUE_W-1:0] r_value;
    logic [olist_pkg::IDX_W-1:0]   r_pos;
    logic                          r_hit;
    olist_pkg::status_t            r_status;

    // Insert-style helpers
    logic [olist_pkg::IDX_W-1:0]   ins_pos;
    logic [olist_pkg::CNT_W-1:0]   ins_pos_ext;
    logic [olist_pkg::CNT_W-1:0]   ins_end;
    logic                          full;
    logic                          pos_in_list;
    logic                          ins_in_list;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign commit     = (state_reg == S_EXEC) && (!out_valid_reg || !result_stall);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_CMP;
            S_CMP:  state_next = S_LOC;
            S_LOC:  state_next = S_RD;
            S_RD:   state_next = S_EXEC;
            S_EXEC: if (commit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
                cnt_reg <= cnt_next;
        end
    end

    // Item capture and first-match position
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= olist_pkg::op_t'(operation);
            pos_reg <= position;
            val_reg <= item_value;
        end
        found_reg <= enc_found;
        fpos_reg  <= enc_first;
    end

    // Row of cells
    for (genvar i = 0; i < olist_pkg::CAPACITY; i++)
    begin : g_cell
        logic [olist_pkg::VALUE_W-1:0] left_v;
        logic [olist_pkg::VALUE_W-1:0] right_v;

        if (i == 0)
        begin : g_first
            assign left_v = '0;
        end
        else
        begin : g_mid_l
            assign left_v = cell_val[i-1];
        end

        if (i == olist_pkg::CAPACITY - 1)
        begin : g_last
            assign right_v = cell_val[i];
        end
        else
        begin : g_mid_r
            assign right_v = cell_val[i+1];
        end

        olist_cell u_cell (
            .clk         (clk),
            .cell_idx    (olist_pkg::IDX_W'(i)),
            .ctrl        (ctrl),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_val[i]),
            .match       (match_vec[i]),
            .rd_value    (cell_rd[i])
        );
    end

    olist_first u_first (
        .match (match_vec),
        .found (enc_found),
        .first (enc_first)
    );

    // Gather the one addressed word from the row
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < olist_pkg::CAPACITY; i++)
            rd_word = rd_word | cell_rd[i];
    end

    // Read address for the gated read
    assign cnt_dec = cnt_reg - olist_pkg::CNT_W'(1);

    always_comb
    begin
        case (op_reg)
            olist_pkg::OP_POP:      rd_idx = cnt_dec[olist_pkg::IDX_W-1:0];
            olist_pkg::OP_SHIFT:    rd_idx = '0;
            olist_pkg::OP_REMOVE_V: rd_idx = fpos_reg;
            default:                rd_idx = pos_reg;
        endcase
    end

    // Insert / extend decision, shared by unshift, insert and put
    assign ins_pos     = (op_reg == olist_pkg::OP_UNSHIFT) ? '0 : pos_reg;
    assign ins_pos_ext = olist_pkg::CNT_W'(ins_pos);
    assign ins_end     = ins_pos_ext + olist_pkg::CNT_W'(1);
    assign full        = (cnt_reg == olist_pkg::CNT_W'(olist_pkg::CAPACITY));
    assign ins_in_list = ins_pos_ext < cnt_reg;
    assign pos_in_list = olist_pkg::CNT_W'(pos_reg) < cnt_reg;

    // Operation decode at the commit step
    always_comb
    begin
        mode     = olist_pkg::CELL_HOLD;
        cmd_pos  = pos_reg;
        cnt_next = cnt_reg;
        r_value  = '0;
        r_pos    = '0;
        r_hit    = 1'b0;
        r_status = olist_pkg::ST_OK;

        case (op_reg)
            olist_pkg::OP_PUSH:
            begin
                if (full)
                    r_status = olist_pkg::ST_FULL;
                else
                begin
                    mode     = olist_pkg::CELL_WRITE;
                    cmd_pos  = cnt_reg[olist_pkg::IDX_W-1:0];
                    cnt_next = cnt_reg + olist_pkg::CNT_W'(1);
                end
            end
            olist_pkg::OP_POP, olist_pkg::OP_SHIFT:
            begin
                if (cnt_reg == '0)
                    r_status = olist_pkg::ST_MISS;
                else
                begin
                    if (op_reg == olist_pkg::OP_SHIFT)
                    begin
                        mode    = olist_pkg::CELL_CLOSE;
                        cmd_pos = '0;
                    end
                    cnt_next = cnt_dec;
                    r_value  = rd_word;
                    r_hit    = 1'b1;
                end
            end
            olist_pkg::OP_UNSHIFT, olist_pkg::OP_INSERT, olist_pkg::OP_PUT:
            begin
                cmd_pos = ins_pos;
                if (op_reg == olist_pkg::OP_PUT && pos_in_list)
                    mode = olist_pkg::CELL_WRITE;
                else if (ins_in_list)
                begin
                    if (full)
                        r_status = olist_pkg::ST_FULL;
                    else
                    begin
                        mode     = olist_pkg::CELL_OPEN;
                        cnt_next = cnt_reg + olist_pkg::CNT_W'(1);
                    end
                end
                else if (ins_end > olist_pkg::CNT_W'(olist_pkg::CAPACITY))
                    r_status = olist_pkg::ST_FULL;
                else
                begin
                    mode     = olist_pkg::CELL_EXTEND;
                    cnt_next = ins_end;
                end
            end
            olist_pkg::OP_GET, olist_pkg::OP_REMOVE_AT:
            begin
                if (!pos_in_list)
                    r_status = olist_pkg::ST_MISS;
                else
                begin
                    if (op_reg == olist_pkg::OP_REMOVE_AT)
                    begin
                        mode     = olist_pkg::CELL_CLOSE;
                        cnt_next = cnt_dec;
                    end
                    r_value = rd_word;
                    r_hit   = 1'b1;
                end
            end
            olist_pkg::OP_FIND, olist_pkg::OP_REMOVE_V:
            begin
                if (!found_reg)
                    r_status = olist_pkg::ST_MISS;
                else
                begin
                    r_pos = fpos_reg;
                    r_hit = 1'b1;
                    if (op_reg == olist_pkg::OP_REMOVE_V)
                    begin
                        mode     = olist_pkg::CELL_CLOSE;
                        cmd_pos  = fpos_reg;
                        cnt_next = cnt_dec;
                        r_value  = rd_word;
                    end
                end
            end
            default:
            begin
                r_status = olist_pkg::ST_MISS;
            end
        endcase
    end

    // Broadcast to the row; cells change only at commit
    always_comb
    begin
        ctrl.mode   = commit ? mode : olist_pkg::CELL_HOLD;
        ctrl.pos    = cmd_pos;
        ctrl.cnt    = cnt_reg;
        ctrl.rd_idx = rd_idx;
        ctrl.value  = val_reg;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_value_reg  <= r_value;
            out_pos_reg    <= r_pos;
            out_hit_reg    <= r_hit;
            out_cnt_reg    <= cnt_next;
            out_status_reg <= r_status;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_value    = out_value_reg;
    assign out_position = out_pos_reg;
    assign hit          = out_hit_reg;
    assign count        = out_cnt_reg;
    assign status       = out_status_reg;

endmodule

// ----- hw/rtl/olist_cell.sv -----
// One list cell: holds one entry, compares it with the search key and
// offers it for reading. Depends on olist_pkg.
module olist_cell (
    input  logic                          clk,
    input  logic [olist_pkg::IDX_W-1:0]   cell_idx,
    input  olist_pkg::cell_ctrl_t         ctrl,
    input  logic [olist_pkg::VALUE_W-1:0] left_value,
    input  logic [olist_pkg::VALUE_W-1:0] right_value,
    output logic [olist_pkg::VALUE_W-1:0] value,
    output logic                          match,
    output logic [olist_pkg::VALUE_W-1:0] rd_value
);

    logic [olist_pkg::VALUE_W-1:0] value_reg;
    logic [olist_pkg::VALUE_W-1:0] value_next;
    logic                          match_reg;
    logic [olist_pkg::VALUE_W-1:0] rd_reg;
    logic [olist_pkg::CNT_W-1:0]   idx_ext;
    logic                          in_list;

    assign idx_ext = olist_pkg::CNT_W'(cell_idx);
    assign in_list = idx_ext < ctrl.cnt;

    // Next entry value per broadcast mode
    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.mode)
            olist_pkg::CELL_HOLD:
            begin
                value_next = value_reg;
            end
            olist_pkg::CELL_WRITE:
            begin
                if (cell_idx == ctrl.pos)
                    value_next = ctrl.value;
            end
            olist_pkg::CELL_OPEN:
            begin
                if (cell_idx == ctrl.pos)
                    value_next = ctrl.value;
                else if (cell_idx > ctrl.pos)
                    value_next = left_value;
            end
            olist_pkg::CELL_CLOSE:
            begin
                if (cell_idx >= ctrl.pos)
                    value_next = right_value;
            end
            olist_pkg::CELL_EXTEND:
            begin
                // gap between old end and new entry is zero-filled
                if (cell_idx == ctrl.pos)
                    value_next = ctrl.value;
                else if (!in_list && cell_idx < ctrl.pos)
                    value_next = '0;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // Entry, key compare and gated read, all registered
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        match_reg <= in_list && (value_reg == ctrl.value);
        rd_reg    <= (cell_idx == ctrl.rd_idx) ? value_reg : '0;
    end

    assign value    = value_reg;
    assign match    = match_reg;
    assign rd_value = rd_reg;

endmodule

// ----- hw/rtl/olist_first.sv -----
// Finds the lowest cell whose match flag is set, in groups of eight.
// Depends on olist_pkg.
module olist_first (
    input  logic [olist_pkg::CAPACITY-1:0] match,
    output logic                           found,
    output logic [olist_pkg::IDX_W-1:0]    first
);

    logic [olist_pkg::PADDED_W-1:0] padded;
    logic [olist_pkg::NGRP-1:0]     grp_any;
    logic [olist_pkg::OFF_W-1:0]    grp_off [olist_pkg::NGRP];
    logic [olist_pkg::GSEL_W-1:0]   grp_sel;

    assign padded = olist_pkg::PADDED_W'(match);

    // Lowest set bit inside each group
    always_comb
    begin
        for (int g = 0; g < olist_pkg::NGRP; g++)
        begin
            grp_any[g] = |padded[g*olist_pkg::GRP +: olist_pkg::GRP];
            grp_off[g] = '0;
            for (int k = olist_pkg::GRP - 1; k >= 0; k--)
            begin
                if (padded[g*olist_pkg::GRP + k])
                    grp_off[g] = olist_pkg::OFF_W'(k);
            end
        end
    end

    // Lowest group that has a hit
    always_comb
    begin
        grp_sel = '0;
        for (int g = olist_pkg::NGRP - 1; g >= 0; g--)
        begin
            if (grp_any[g])
                grp_sel = olist_pkg::GSEL_W'(g);
        end
    end

    assign found = |grp_any;
    assign first = olist_pkg::IDX_W'({grp_sel, grp_off[grp_sel]});

endmodule
